### rtl/assert_macros.svh
// Assertion macros for the RTL; windowed_trimmed_averages_core uses them.
// Each macro expects signals named clock and reset in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define WTA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define WTA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

### rtl/wta_pkg.sv
// Shared constants and pipeline payload types for the trimmed-average block.
// No dependencies.
`default_nettype none

package wta_pkg;

   localparam int SAMPLE_BITS  = 24;
   localparam int WINDOW_DEPTH = 12;
   localparam int SEEN_BITS    = 4;
   // twelve samples of SAMPLE_BITS each fit with four extra bits
   localparam int SUM_BITS     = SAMPLE_BITS + 4;
   // quotient estimate is off by at most one for totals below 2**SUM_BITS
   localparam int RECIP_SHIFT  = SUM_BITS + 4;
   localparam int PROD_BITS    = SUM_BITS + RECIP_SHIFT;

   localparam int MEAN_COUNT   = 3;
   localparam int FIVE_COUNT   = 5;
   localparam int TWELVE_COUNT = 12;
   localparam int DIV_THREE    = 3;
   localparam int DIV_TEN      = 10;

   localparam logic [RECIP_SHIFT-1:0] RECIP_THREE =
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd3);
   localparam logic [RECIP_SHIFT-1:0] RECIP_TEN =
      RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / 64'd10);

   typedef struct packed {
      logic three;
      logic five;
      logic twelve;
   } wta_flags_type;

   typedef struct packed {
      logic [SUM_BITS-1:0] tot3;
      logic [SUM_BITS-1:0] tot5;
      logic [SUM_BITS-1:0] tot12;
      wta_flags_type       flags;
   } wta_totals_type;

endpackage

`default_nettype wire

### rtl/windowed_trimmed_averages_core.sv
// Sliding-window trimmed averages of a sample stream.
//
// Request channel (req_): one unsigned time sample per transfer, with a
// restart flag that clears the history before that sample is taken.
// Response channel (rsp_): one result per request: mean of the last three
// samples, last five less min and max over three, last twelve less min and
// max over ten, each with a flag that is set once enough samples are held;
// a value whose flag is clear reads as zero.
// A transfer happens on a rising edge with valid high and stall low.
// Throughput: one request per cycle while rsp_stall is low, set by the
// window shift register that updates on every request transfer.
// After the request transfer, the response passes through the window, partial
// sums/extremes, totals, reciprocal product and result registers.
// Reset clears the window, the sample count and all pipeline valids.
// When rsp_stall holds a valid result, the result register keeps it and
// the pipeline fills empty stages; req_stall rises only once all are full.
// Depends on wta_pkg, wta_divide and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module windowed_trimmed_averages_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [wta_pkg::SAMPLE_BITS-1:0] req_time_sample,
   input  wire logic                           req_restart_session,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [wta_pkg::SAMPLE_BITS-1:0]     rsp_mean_of_three,
   output logic                                rsp_mean_of_three_valid,
   output logic [wta_pkg::SAMPLE_BITS-1:0]     rsp_trimmed_of_five,
   output logic                                rsp_trimmed_of_five_valid,
   output logic [wta_pkg::SAMPLE_BITS-1:0]     rsp_trimmed_of_twelve,
   output logic                                rsp_trimmed_of_twelve_valid
);

   localparam int DB = wta_pkg::SAMPLE_BITS;
   localparam int SB = wta_pkg::SUM_BITS;
   localparam int WD = wta_pkg::WINDOW_DEPTH;
   localparam int CB = wta_pkg::SEEN_BITS;

   function automatic logic [DB-1:0] min_of(input logic [DB-1:0] a,
                                            input logic [DB-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [DB-1:0] max_of(input logic [DB-1:0] a,
                                            input logic [DB-1:0] b);
      return (a > b) ? a : b;
   endfunction

   // ---------------- stage 0: window shift register
   logic [DB-1:0]          window_ff [WD];
   logic [DB-1:0]          window_in [WD];
   logic [CB-1:0]          seen_ff, seen_in;
   logic                   v0_ff, v0_in;
   wta_pkg::wta_flags_type flags0_ff, flags0_in;
   logic                   rdy0, rdy1, rdy2, div_ready;
   logic                   req_take;

   assign rdy0      = !v0_ff || rdy1;
   assign req_stall = !rdy0;
   assign req_take  = req_valid && rdy0;

   always_comb begin
      window_in[0] = req_time_sample;
      for (int i = 1; i < WD; i++) begin
         window_in[i] = req_restart_session ? '0 : window_ff[i-1];
      end
      if (req_restart_session) begin
         seen_in = CB'(1);
      end else if (seen_ff < CB'(WD)) begin
         seen_in = seen_ff + CB'(1);
      end else begin
         seen_in = seen_ff;
      end
      flags0_in.three  = seen_in >= CB'(wta_pkg::MEAN_COUNT);
      flags0_in.five   = seen_in >= CB'(wta_pkg::FIVE_COUNT);
      flags0_in.twelve = seen_in >= CB'(wta_pkg::TWELVE_COUNT);
      v0_in = rdy0 ? req_valid : v0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WD; i++) begin
            window_ff[i] <= '0;
         end
         seen_ff <= '0;
         v0_ff   <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         if (req_take) begin
            for (int i = 0; i < WD; i++) begin
               window_ff[i] <= window_in[i];
            end
            seen_ff <= seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         flags0_ff <= flags0_in;
      end
   end

   // ---------------- stage 1: partial sums and extremes
   logic                   v1_ff, v1_in;
   wta_pkg::wta_flags_type flags1_ff;
   logic [SB-1:0]          sum3_ff, sum34_ff, suma_ff, sumb_ff;
   logic [SB-1:0]          sum3_in, sum34_in, suma_in, sumb_in;
   logic [DB-1:0]          min5_ff, max5_ff, minr_ff, maxr_ff;
   logic [DB-1:0]          min5_in, max5_in, minr_in, maxr_in;

   assign rdy1  = !v1_ff || rdy2;
   assign v1_in = rdy1 ? v0_ff : v1_ff;

   always_comb begin
      sum3_in  = SB'(window_ff[0]) + SB'(window_ff[1]) + SB'(window_ff[2]);
      sum34_in = SB'(window_ff[3]) + SB'(window_ff[4]);
      suma_in  = SB'(window_ff[5]) + SB'(window_ff[6])
               + SB'(window_ff[7]) + SB'(window_ff[8]);
      sumb_in  = SB'(window_ff[9]) + SB'(window_ff[10]) + SB'(window_ff[11]);
      min5_in = min_of(min_of(window_ff[0], window_ff[1]),
                       min_of(min_of(window_ff[2], window_ff[3]), window_ff[4]));
      max5_in = max_of(max_of(window_ff[0], window_ff[1]),
                       max_of(max_of(window_ff[2], window_ff[3]), window_ff[4]));
      minr_in = min_of(min_of(min_of(window_ff[5], window_ff[6]),
                              min_of(window_ff[7], window_ff[8])),
                       min_of(min_of(window_ff[9], window_ff[10]), window_ff[11]));
      maxr_in = max_of(max_of(max_of(window_ff[5], window_ff[6]),
                              max_of(window_ff[7], window_ff[8])),
                       max_of(max_of(window_ff[9], window_ff[10]), window_ff[11]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && v0_ff) begin
         sum3_ff   <= sum3_in;
         sum34_ff  <= sum34_in;
         suma_ff   <= suma_in;
         sumb_ff   <= sumb_in;
         min5_ff   <= min5_in;
         max5_ff   <= max5_in;
         minr_ff   <= minr_in;
         maxr_ff   <= maxr_in;
         flags1_ff <= flags0_ff;
      end
   end

   // ---------------- stage 2: trimmed totals
   logic                    v2_ff, v2_in;
   wta_pkg::wta_totals_type tot_ff, tot_in;
   logic [SB-1:0]           sum5, sum12;
   logic [DB-1:0]           min12, max12;

   assign rdy2  = !v2_ff || div_ready;
   assign v2_in = rdy2 ? v1_ff : v2_ff;

   always_comb begin
      sum5  = sum3_ff + sum34_ff;
      sum12 = sum5 + suma_ff + sumb_ff;
      min12 = min_of(min5_ff, minr_ff);
      max12 = max_of(max5_ff, maxr_ff);
      tot_in.tot3  = sum3_ff;
      tot_in.tot5  = sum5 - SB'(min5_ff) - SB'(max5_ff);
      tot_in.tot12 = sum12 - SB'(min12) - SB'(max12);
      tot_in.flags = flags1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         tot_ff <= tot_in;
      end
   end

   // ---------------- stages 3 and 4: division and result register
   wta_divide u_divide (
      .clock                       (clock),
      .reset                       (reset),
      .in_valid                    (v2_ff),
      .in_totals                   (tot_ff),
      .in_ready                    (div_ready),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_mean_of_three           (rsp_mean_of_three),
      .rsp_mean_of_three_valid     (rsp_mean_of_three_valid),
      .rsp_trimmed_of_five         (rsp_trimmed_of_five),
      .rsp_trimmed_of_five_valid   (rsp_trimmed_of_five_valid),
      .rsp_trimmed_of_twelve       (rsp_trimmed_of_twelve),
      .rsp_trimmed_of_twelve_valid (rsp_trimmed_of_twelve_valid)
   );

   // ---------------- checks
   `WTA_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid,
      "response valid right after reset")
   `WTA_ASSERT(a_seen_saturates, seen_ff <= CB'(WD),
      "sample count above window depth")
   `WTA_ASSERT(a_restart_count, (req_take && req_restart_session) |=> seen_ff == CB'(1),
      "restart did not reset sample count")
   `WTA_ASSERT(a_flags_nested, v0_ff |-> ((!flags0_ff.twelve || flags0_ff.five)
      && (!flags0_ff.five || flags0_ff.three)), "valid flags out of order")
   `WTA_ASSERT(a_invalid_reads_zero, (rsp_valid && !rsp_trimmed_of_twelve_valid)
      |-> rsp_trimmed_of_twelve == '0, "unflagged twelve-sample value not zero")

endmodule

`default_nettype wire

### rtl/wta_divide.sv
// Constant division stages: reciprocal multiply, then one-step correction
// into the result register. Depends on wta_pkg.
`default_nettype none

module wta_divide (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire wta_pkg::wta_totals_type        in_totals,
   output logic                                in_ready,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [wta_pkg::SAMPLE_BITS-1:0]     rsp_mean_of_three,
   output logic                                rsp_mean_of_three_valid,
   output logic [wta_pkg::SAMPLE_BITS-1:0]     rsp_trimmed_of_five,
   output logic                                rsp_trimmed_of_five_valid,
   output logic [wta_pkg::SAMPLE_BITS-1:0]     rsp_trimmed_of_twelve,
   output logic                                rsp_trimmed_of_twelve_valid
);

   localparam int SB = wta_pkg::SUM_BITS;
   localparam int PB = wta_pkg::PROD_BITS;
   localparam int DB = wta_pkg::SAMPLE_BITS;

   // estimate is floor or floor-1; fix with one compare
   function automatic logic [SB-1:0] fix_quotient(input logic [SB-1:0] total,
                                                  input logic [PB-1:0] prod,
                                                  input logic [SB-1:0] divisor);
      logic [SB-1:0] q0;
      logic [SB-1:0] rem;
      q0  = prod[PB-1:wta_pkg::RECIP_SHIFT];
      rem = total - SB'(q0 * divisor);
      return (rem >= divisor) ? SB'(q0 + SB'(1)) : q0;
   endfunction

   logic                    v3_ff, v3_in;
   wta_pkg::wta_totals_type tot_ff;
   logic [PB-1:0]           prod3_ff, prod5_ff, prod12_ff;
   logic                    out_ready;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DB-1:0]           mean3_ff, trim5_ff, trim12_ff;
   logic [DB-1:0]           mean3_in, trim5_in, trim12_in;
   wta_pkg::wta_flags_type  flags_ff;
   logic [SB-1:0]           q3, q5, q12;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign in_ready  = !v3_ff || out_ready;

   assign v3_in        = in_ready ? in_valid : v3_ff;
   assign rsp_valid_in = out_ready ? v3_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v3_ff        <= v3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         tot_ff    <= in_totals;
         prod3_ff  <= PB'(in_totals.tot3)  * PB'(wta_pkg::RECIP_THREE);
         prod5_ff  <= PB'(in_totals.tot5)  * PB'(wta_pkg::RECIP_THREE);
         prod12_ff <= PB'(in_totals.tot12) * PB'(wta_pkg::RECIP_TEN);
      end
   end

   always_comb begin
      q3  = fix_quotient(tot_ff.tot3,  prod3_ff,  SB'(wta_pkg::DIV_THREE));
      q5  = fix_quotient(tot_ff.tot5,  prod5_ff,  SB'(wta_pkg::DIV_THREE));
      q12 = fix_quotient(tot_ff.tot12, prod12_ff, SB'(wta_pkg::DIV_TEN));
      mean3_in  = tot_ff.flags.three  ? q3[DB-1:0]  : '0;
      trim5_in  = tot_ff.flags.five   ? q5[DB-1:0]  : '0;
      trim12_in = tot_ff.flags.twelve ? q12[DB-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (out_ready && v3_ff) begin
         mean3_ff  <= mean3_in;
         trim5_ff  <= trim5_in;
         trim12_ff <= trim12_in;
         flags_ff  <= tot_ff.flags;
      end
   end

   assign rsp_valid                   = rsp_valid_ff;
   assign rsp_mean_of_three           = mean3_ff;
   assign rsp_mean_of_three_valid     = flags_ff.three;
   assign rsp_trimmed_of_five         = trim5_ff;
   assign rsp_trimmed_of_five_valid   = flags_ff.five;
   assign rsp_trimmed_of_twelve       = trim12_ff;
   assign rsp_trimmed_of_twelve_valid = flags_ff.twelve;

endmodule

`default_nettype wire

### dv/tb_windowed_trimmed_averages_core.sv
// Self-checking testbench for windowed_trimmed_averages_core.
// Directed and random sessions drive the request channel; a local model of the
// sample history predicts each response. Depends on wta_pkg and the core RTL.
module tb_windowed_trimmed_averages_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS    = wta_pkg::SAMPLE_BITS;
   localparam int WINDOW_DEPTH   = wta_pkg::WINDOW_DEPTH;
   localparam int MEAN_COUNT     = wta_pkg::MEAN_COUNT;
   localparam int FIVE_COUNT     = wta_pkg::FIVE_COUNT;
   localparam int TWELVE_COUNT   = wta_pkg::TWELVE_COUNT;
   localparam int DIV_THREE      = wta_pkg::DIV_THREE;
   localparam int DIV_TEN        = wta_pkg::DIV_TEN;

   localparam int RANDOM_ITEMS   = 1525;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam logic [SAMPLE_BITS-1:0] MAX_SAMPLE = '1;

   typedef struct {
      logic [SAMPLE_BITS-1:0] sample;
      logic                   restart;
      int unsigned            gap;
      bit                     drain_first;
   } sample_item_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] mean3;
      logic                   mean3_ok;
      logic [SAMPLE_BITS-1:0] trim5;
      logic                   trim5_ok;
      logic [SAMPLE_BITS-1:0] trim12;
      logic                   trim12_ok;
   } averages_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid           = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_BITS-1:0] req_time_sample     = '0;
   logic                   req_restart_session = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall           = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_mean_of_three;
   logic                   rsp_mean_of_three_valid;
   logic [SAMPLE_BITS-1:0] rsp_trimmed_of_five;
   logic                   rsp_trimmed_of_five_valid;
   logic [SAMPLE_BITS-1:0] rsp_trimmed_of_twelve;
   logic                   rsp_trimmed_of_twelve_valid;

   sample_item_type pending_q[$];
   averages_type    expected_q[$];

   // local copy of the sliding window, index 0 newest
   logic [SAMPLE_BITS-1:0] history [WINDOW_DEPTH];
   int unsigned            held;

   int unsigned samples_sent;
   int unsigned results_seen;
   int unsigned fail_count;
   int unsigned idle_cycles;
   int unsigned stall_left;
   int unsigned quiet_run;
   bit          rsp_quiet;

   windowed_trimmed_averages_core DUT (
      .clock                       (clock),
      .reset                       (reset),
      .req_valid                   (req_valid),
      .req_stall                   (req_stall),
      .req_time_sample             (req_time_sample),
      .req_restart_session         (req_restart_session),
      .rsp_valid                   (rsp_valid),
      .rsp_stall                   (rsp_stall),
      .rsp_mean_of_three           (rsp_mean_of_three),
      .rsp_mean_of_three_valid     (rsp_mean_of_three_valid),
      .rsp_trimmed_of_five         (rsp_trimmed_of_five),
      .rsp_trimmed_of_five_valid   (rsp_trimmed_of_five_valid),
      .rsp_trimmed_of_twelve       (rsp_trimmed_of_twelve),
      .rsp_trimmed_of_twelve_valid (rsp_trimmed_of_twelve_valid)
   );

   always #4 clock = ~clock;

   // Sum of the newest n samples, optionally less one minimum and one maximum.
   function automatic longint unsigned newest_total(int unsigned n, bit trim);
      longint unsigned total;
      longint unsigned lo;
      longint unsigned hi;
      total = 0;
      lo    = history[0];
      hi    = history[0];
      for (int i = 0; i < n; i++) begin
         total += history[i];
         if (history[i] < lo) lo = history[i];
         if (history[i] > hi) hi = history[i];
      end
      if (trim) total = total - lo - hi;
      return total;
   endfunction

   task automatic take_sample(input logic [SAMPLE_BITS-1:0] sample, input logic restart);
      averages_type avg;
      if (restart) begin
         foreach (history[i]) history[i] = '0;
         held = 0;
      end
      for (int i = WINDOW_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = sample;
      if (held < WINDOW_DEPTH) held++;
      avg = '0;
      if (held >= MEAN_COUNT) begin
         avg.mean3    = SAMPLE_BITS'(newest_total(MEAN_COUNT, 1'b0) / DIV_THREE);
         avg.mean3_ok = 1'b1;
      end
      if (held >= FIVE_COUNT) begin
         avg.trim5    = SAMPLE_BITS'(newest_total(FIVE_COUNT, 1'b1) / DIV_THREE);
         avg.trim5_ok = 1'b1;
      end
      if (held >= TWELVE_COUNT) begin
         avg.trim12    = SAMPLE_BITS'(newest_total(TWELVE_COUNT, 1'b1) / DIV_TEN);
         avg.trim12_ok = 1'b1;
      end
      expected_q.push_back(avg);
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic add_item(input logic [SAMPLE_BITS-1:0] sample, input logic restart,
                           input int unsigned gap, input bit drain_first);
      sample_item_type item;
      item.sample      = sample;
      item.restart     = restart;
      item.gap         = gap;
      item.drain_first = drain_first;
      pending_q.push_back(item);
   endtask

   // Request driver
   always @(posedge clock) begin
      sample_item_type nxt;
      if (reset) begin
         req_valid           <= 1'b0;
         req_time_sample     <= '0;
         req_restart_session <= 1'b0;
         idle_cycles = 0;
         foreach (history[i]) history[i] = '0;
         held = 0;
      end else begin
         if (req_valid && !req_stall) begin
            take_sample(req_time_sample, req_restart_session);
            samples_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_q.size() != 0 && idle_cycles >= pending_q[0].gap &&
                !(pending_q[0].drain_first && expected_q.size() != 0)) begin
               nxt = pending_q.pop_front();
               req_valid           <= 1'b1;
               req_time_sample     <= nxt.sample;
               req_restart_session <= nxt.restart;
               idle_cycles = 0;
            end else begin
               // payload is don't-care while idle
               req_valid           <= 1'b0;
               req_time_sample     <= SAMPLE_BITS'($urandom);
               req_restart_session <= 1'($urandom);
               idle_cycles++;
            end
         end
      end
   end

   // Response monitor and stall generator
   always @(posedge clock) begin
      averages_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         quiet_run  = 0;
         rsp_quiet  = 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               $error("unexpected response transfer with no request outstanding");
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               check_field("mean_of_three", want.mean3, rsp_mean_of_three);
               check_field("mean_of_three_valid", want.mean3_ok, rsp_mean_of_three_valid);
               check_field("trimmed_of_five", want.trim5, rsp_trimmed_of_five);
               check_field("trimmed_of_five_valid", want.trim5_ok,
                           rsp_trimmed_of_five_valid);
               check_field("trimmed_of_twelve", want.trim12, rsp_trimmed_of_twelve);
               check_field("trimmed_of_twelve_valid", want.trim12_ok,
                           rsp_trimmed_of_twelve_valid);
            end
            if (quiet_run == 0) begin
               rsp_quiet = ($urandom_range(0, 3) == 0);
               quiet_run = 100;
            end
            quiet_run--;
            stall_left = rsp_quiet ? 0 : $urandom_range(0, 6);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: cycles without any transfer on either channel
   always @(posedge clock) begin
      int unsigned dead_cycles;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) dead_cycles = 0;
         else dead_cycles++;
         if (dead_cycles >= WATCHDOG_LIMIT) begin
            $display("windowed_trimmed_averages_core test failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned total_items;
      int unsigned session_len;
      int unsigned style;
      int unsigned sessions;
      bit          zero_gaps;
      logic [SAMPLE_BITS-1:0] sample;
      logic                   restart;

      // too few samples, then a window full of the largest sample
      add_item('0, 1'b1, $urandom_range(0, 6), 1'b0);
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
         add_item(MAX_SAMPLE, 1'b0, $urandom_range(0, 6), 1'b0);
      end
      add_item('0, 1'b0, $urandom_range(0, 6), 1'b0);
      add_item(SAMPLE_BITS'(1), 1'b0, $urandom_range(0, 6), 1'b0);
      // restart with drained pipeline, then tied extremes
      add_item(MAX_SAMPLE, 1'b1, 0, 1'b1);
      for (int i = 0; i < 5; i++) add_item(SAMPLE_BITS'(7), 1'b0, $urandom_range(0, 6), 1'b0);
      add_item(SAMPLE_BITS'(24'h800000), 1'b1, 0, 1'b0);
      add_item(SAMPLE_BITS'(24'h555555), 1'b0, 0, 1'b0);
      add_item(SAMPLE_BITS'(24'hAAAAAA), 1'b0, 0, 1'b0);

      total_items = pending_q.size() + RANDOM_ITEMS;
      sessions = 0;
      while (pending_q.size() < total_items) begin
         session_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 11)
                                                    : $urandom_range(12, 60);
         style     = $urandom_range(0, 4);
         zero_gaps = ($urandom_range(0, 3) == 0);
         sessions++;
         for (int k = 0; k < session_len; k++) begin
            case (style)
               0:       sample = SAMPLE_BITS'($urandom);
               1:       sample = SAMPLE_BITS'($urandom_range(0, 15));
               2:       sample = MAX_SAMPLE - SAMPLE_BITS'($urandom_range(0, 15));
               3:       sample = $urandom_range(0, 1) ? MAX_SAMPLE : '0;
               default: sample = $urandom_range(0, 1) ? SAMPLE_BITS'($urandom)
                                         : SAMPLE_BITS'($urandom_range(900, 1100));
            endcase
            // most sessions open with a restart; a rare one breaks in mid-session
            restart = (k == 0 && $urandom_range(0, 7) != 0) || ($urandom_range(0, 63) == 0);
            add_item(sample, restart, zero_gaps ? 0 : $urandom_range(0, 6),
                     (k == 0) && (sessions % 12 == 0));
         end
      end
      total_items = pending_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (samples_sent < total_items || expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && expected_q.size() == 0 && results_seen == samples_sent) begin
         $display("windowed_trimmed_averages_core test passed");
      end else begin
         $display("windowed_trimmed_averages_core test failed");
      end
      $finish;
   end

endmodule

### windowed_trimmed_averages_core.f
+incdir+rtl
rtl/wta_pkg.sv
rtl/wta_divide.sv
rtl/windowed_trimmed_averages_core.sv
dv/tb_windowed_trimmed_averages_core.sv
